// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by binary_to_decimal_ascii_unit in this folder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication, disabled while reset is asserted.
`define B2D_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Clocked implication checked in the following cycle.
`define B2D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/b2d_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b2d_pkg
// Shared constants and types of the binary to decimal ASCII converter.
// ---------------------------------------------------------------------------
package b2d_pkg;

  localparam int VALUE_WIDTH = 64;
  localparam int MAX_DIGITS  = 20;
  localparam int IN_WIDTH    = 64;

  localparam int BCD_W   = MAX_DIGITS * 4;
  localparam int BITCNT_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
  localparam int LEFT_W  = $clog2(MAX_DIGITS + 1);

  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;

  // status from the double-dabble core to the character sequencer
  typedef struct packed {
    logic busy;
    logic done;
    logic ovf;
  } dab_stat_t;

endpackage

// ===== rtl/core/b2d_dabble.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b2d_dabble
// Shift-and-add-3 binary to BCD converter, one operand bit per cycle.
// ---------------------------------------------------------------------------
module b2d_dabble (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic [b2d_pkg::VALUE_WIDTH-1:0]        mag,
  output logic [b2d_pkg::BCD_W-1:0]              bcd,
  output b2d_pkg::dab_stat_t                     stat
);

  logic [b2d_pkg::VALUE_WIDTH-1:0] bin_r;
  logic [3:0]                      dig_r [b2d_pkg::MAX_DIGITS];
  logic [3:0]                      adj   [b2d_pkg::MAX_DIGITS];
  logic [b2d_pkg::BITCNT_W-1:0]    cnt_r;
  logic                            busy_r;
  logic                            done_r;
  logic                            ovf_r;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < b2d_pkg::MAX_DIGITS; i++) begin
      adj[i] = (dig_r[i] >= 4'd5) ? (dig_r[i] + 4'd3) : dig_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ovf_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        ovf_r  <= 1'b0;
        cnt_r  <= '0;
        bin_r  <= mag;
        for (int i = 0; i < b2d_pkg::MAX_DIGITS; i++) begin
          dig_r[i] <= 4'd0;
        end
      end else if (busy_r) begin
        bin_r    <= bin_r << 1;
        dig_r[0] <= {adj[0][2:0], bin_r[b2d_pkg::VALUE_WIDTH-1]};
        for (int i = 1; i < b2d_pkg::MAX_DIGITS; i++) begin
          dig_r[i] <= {adj[i][2:0], adj[i-1][3]};
        end
        // a carry out of the top digit means digits were dropped
        ovf_r <= ovf_r | adj[b2d_pkg::MAX_DIGITS-1][3];
        if (cnt_r == b2d_pkg::BITCNT_W'(b2d_pkg::VALUE_WIDTH - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < b2d_pkg::MAX_DIGITS; i++) begin
      bcd[i*4 +: 4] = dig_r[i];
    end
    stat.busy = busy_r;
    stat.done = done_r;
    stat.ovf  = ovf_r;
  end

endmodule

// ===== rtl/core/binary_to_decimal_ascii_unit.sv =====
`timescale 1ns / 1ps
// Timing: the first character is offered after the shift-and-add-3 conversion and after
//   one skip step per leading zero digit dropped, then one character per cycle while out_ready is high.
// Requests: a new request is taken only in idle, after the last character of the previous
//   one has been taken; each of the 20 digit slots is either skipped or sent.
// Reset: synchronous active-low rst_n returns to idle with no character pending.
// ---------------------------------------------------------------------------
// binary_to_decimal_ascii_unit
// Converts a binary operand with a negate flag to signed decimal ASCII text,
// most significant character first, with last on the final digit.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module binary_to_decimal_ascii_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [b2d_pkg::IN_WIDTH-1:0] in_value,
  input  logic                         in_negative,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   out_char,
  output logic                         out_last
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SKIP,
    S_SIGN,
    S_EMIT
  } state_t;

  state_t                           state_r;
  logic                             neg_r;
  logic                             ovf_r;
  logic [b2d_pkg::BCD_W-1:0]        dig_r;
  logic [b2d_pkg::LEFT_W-1:0]       left_r;
  logic                             out_valid_r;
  logic [7:0]                       out_char_r;
  logic                             out_last_r;

  logic [b2d_pkg::VALUE_WIDTH-1:0]  opnd;
  logic [b2d_pkg::VALUE_WIDTH-1:0]  mag_nxt;
  logic                             start;
  logic [b2d_pkg::BCD_W-1:0]        bcd;
  b2d_pkg::dab_stat_t               stat;
  logic [3:0]                       top_dig;
  logic                             top_last;
  logic                             out_take;
  logic                             char_ok;

  // Only the low VALUE_WIDTH bits of the operand count; negate modulo 2^width.
  assign opnd    = in_value[b2d_pkg::VALUE_WIDTH-1:0];
  assign mag_nxt = in_negative ? (~opnd + 1'b1) : opnd;
  assign start   = in_valid && in_ready;

  b2d_dabble u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .mag   (mag_nxt),
    .bcd   (bcd),
    .stat  (stat)
  );

  // Digits leave from the most significant end of the shift register.
  assign top_dig  = dig_r[b2d_pkg::BCD_W-1 -: 4];
  assign top_last = (left_r == b2d_pkg::LEFT_W'(1));
  assign out_take = out_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      neg_r       <= 1'b0;
      ovf_r       <= 1'b0;
      left_r      <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            // a minus sign only for a nonzero negative operand
            neg_r   <= in_negative && (opnd != '0);
            state_r <= S_CONV;
          end
        end
        S_CONV: begin
          if (stat.done) begin
            dig_r   <= bcd;
            ovf_r   <= stat.ovf;
            left_r  <= b2d_pkg::LEFT_W'(b2d_pkg::MAX_DIGITS);
            state_r <= S_SKIP;
          end
        end
        S_SKIP: begin
          // drop leading zeros, but always keep the units digit; after a
          // truncation every kept digit goes out, zeros included
          if (top_dig == 4'd0 && !top_last && !ovf_r) begin
            dig_r  <= dig_r << 4;
            left_r <= left_r - 1'b1;
          end else if (neg_r) begin
            out_valid_r <= 1'b1;
            out_char_r  <= b2d_pkg::CHAR_MINUS;
            out_last_r  <= 1'b0;
            state_r     <= S_SIGN;
          end else begin
            out_valid_r <= 1'b1;
            out_char_r  <= b2d_pkg::CHAR_ZERO + {4'd0, top_dig};
            out_last_r  <= top_last;
            dig_r       <= dig_r << 4;
            left_r      <= left_r - 1'b1;
            state_r     <= S_EMIT;
          end
        end
        S_SIGN: begin
          // hold the sign until taken, then advance to the first digit
          if (out_take) begin
            out_char_r <= b2d_pkg::CHAR_ZERO + {4'd0, top_dig};
            out_last_r <= top_last;
            dig_r      <= dig_r << 4;
            left_r     <= left_r - 1'b1;
            state_r    <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_take) begin
            if (out_last_r) begin
              out_valid_r <= 1'b0;
              state_r     <= S_IDLE;
            end else begin
              out_char_r <= b2d_pkg::CHAR_ZERO + {4'd0, top_dig};
              out_last_r <= top_last;
              dig_r      <= dig_r << 4;
              left_r     <= left_r - 1'b1;
            end
          end
        end
        default: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  // a minus sign or a decimal digit
  assign char_ok = (out_char == b2d_pkg::CHAR_MINUS) ||
                   ((out_char >= b2d_pkg::CHAR_ZERO) && (out_char <= b2d_pkg::CHAR_ZERO + 8'd9));

  `B2D_ASSERT(a_char_range, out_valid, char_ok, "character out of range")
  `B2D_ASSERT(a_idle_quiet, in_ready, !out_valid && !stat.busy, "idle with work pending")
  `B2D_ASSERT_NEXT(a_start_busy, start, stat.busy && !out_valid, "conversion did not start")
  `B2D_ASSERT(a_sign_not_last, out_valid && (out_char == b2d_pkg::CHAR_MINUS), !out_last, "sign marked last")

endmodule

// ===== sim/tb_binary_to_decimal_ascii_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_binary_to_decimal_ascii_unit
// Feeds 64-bit operands with a negate flag into the converter and checks
// every ASCII character and last flag against a decimal text predictor,
// with random idling on both channels, one long output hold-off and two
// full drains of the converter.
// ---------------------------------------------------------------------------
module tb_binary_to_decimal_ascii_unit;

  localparam int TEXT_BYTES      = b2d_pkg::MAX_DIGITS + 1;  // optional '-' plus every digit
  localparam int TEXT_W          = TEXT_BYTES * 8;
  localparam int DECIMAL_BASE    = 10;
  localparam int RANDOM_REQUESTS = 161;
  localparam int CALM_REQUESTS   = 30;   // tail of the run without any idling
  localparam int LONG_HOLD       = 400;  // output hold-off that backs up the input
  localparam int TAIL_CYCLES     = 120;  // more than one full conversion
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DIRECTED_COUNT  = 19;

  localparam logic [TEXT_W-1:0] PREDICTED = '0;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } ascii_char_t;

  // One directed request. A nonzero text is the exact expected output,
  // right-aligned; PREDICTED hands the row to the predictor.
  typedef struct packed {
    logic [b2d_pkg::IN_WIDTH-1:0] value;
    logic                         negative;
    logic [TEXT_W-1:0]            text;
  } directed_row_t;

  logic                         clk;
  logic                         rst_n       = 1'b0;
  logic                         in_valid    = 1'b0;
  logic                         in_ready;
  logic [b2d_pkg::IN_WIDTH-1:0] in_value    = '0;
  logic                         in_negative = 1'b0;
  logic                         out_valid;
  logic                         out_ready   = 1'b0;
  logic [7:0]                   out_char;
  logic                         out_last;

  ascii_char_t expected_chars_q[$];
  int          mismatch_count = 0;
  int          quiet_cycles   = 0;
  bit          long_hold_req  = 1'b0;
  bit          calm_tail      = 1'b0;

  directed_row_t directed_rows [DIRECTED_COUNT] = '{
    '{64'd0,                     1'b0, "0"},
    '{64'd0,                     1'b1, "0"},
    '{64'd1,                     1'b0, "1"},
    '{64'd9,                     1'b0, "9"},
    '{64'd10,                    1'b0, "10"},
    '{64'hFFFF_FFFF_FFFF_FFFF,   1'b0, "18446744073709551615"},
    '{64'hFFFF_FFFF_FFFF_FFFF,   1'b1, "-1"},
    '{64'd1,                     1'b1, "-18446744073709551615"},
    '{64'h8000_0000_0000_0000,   1'b0, "9223372036854775808"},
    '{64'h8000_0000_0000_0000,   1'b1, "-9223372036854775808"},
    '{64'h7FFF_FFFF_FFFF_FFFF,   1'b0, "9223372036854775807"},
    '{64'd10000000000000000000,  1'b0, PREDICTED},
    '{64'd9999999999999999999,   1'b0, PREDICTED},
    '{64'd100,                   1'b1, PREDICTED},
    '{64'hFFFF_FFFF_FFFF_FF9C,   1'b1, PREDICTED},
    '{64'hAAAA_AAAA_AAAA_AAAA,   1'b0, PREDICTED},
    '{64'h5555_5555_5555_5555,   1'b1, PREDICTED},
    '{64'd1000000007,            1'b0, PREDICTED},
    '{64'hFFFF_FFFF_FFFF_FFF6,   1'b1, PREDICTED}
  };

  binary_to_decimal_ascii_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_value   (in_value),
    .in_negative(in_negative),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_char   (out_char),
    .out_last   (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Predict the decimal text of one request: negate modulo 2^VALUE_WIDTH
  // when asked, peel digits least significant first, then queue them most
  // significant first behind an optional minus sign.
  task automatic push_decimal_chars(input logic [b2d_pkg::IN_WIDTH-1:0] operand,
                                    input logic negate);
    logic [63:0] mask;
    logic [63:0] magnitude;
    logic [3:0]  digits [b2d_pkg::MAX_DIGITS];
    int          count;
    mask      = {64{1'b1}} >> (64 - b2d_pkg::VALUE_WIDTH);
    magnitude = operand & mask;
    if (negate) magnitude = (64'd0 - magnitude) & mask;
    count = 0;
    if (magnitude == 0) begin
      // zero never carries a sign, even with the negate flag set
      expected_chars_q.push_back(ascii_char_t'{b2d_pkg::CHAR_ZERO, 1'b1});
    end else begin
      while (magnitude != 0 && count < b2d_pkg::MAX_DIGITS) begin
        digits[count] = 4'(magnitude % DECIMAL_BASE);
        magnitude     = magnitude / DECIMAL_BASE;
        count++;
      end
      if (negate) expected_chars_q.push_back(ascii_char_t'{b2d_pkg::CHAR_MINUS, 1'b0});
      for (int i = count - 1; i >= 0; i--) begin
        expected_chars_q.push_back(ascii_char_t'{b2d_pkg::CHAR_ZERO + 8'(digits[i]), i == 0});
      end
    end
  endtask

  // Offer one request and hold it until the converter takes it, then queue
  // what it must produce. Leave in_valid high so back-to-back requests
  // never see a low cycle between them.
  task automatic send_request(input logic [b2d_pkg::IN_WIDTH-1:0] value, input logic negative,
                              input logic [TEXT_W-1:0] text);
    in_valid    <= 1'b1;
    in_value    <= value;
    in_negative <= negative;
    do @(posedge clk); while (!in_ready);
    if (text == PREDICTED) begin
      push_decimal_chars(value, negative);
    end else begin
      // typed text: skip the zero padding in front, last sits on byte 0
      for (int b = TEXT_BYTES - 1; b >= 0; b--) begin
        if (text[b*8 +: 8] != 8'd0) begin
          expected_chars_q.push_back(ascii_char_t'{text[b*8 +: 8], b == 0});
        end
      end
    end
  endtask

  // Insert a random idle burst on the request side, except in the calm tail.
  task automatic maybe_idle_sender();
    if (!calm_tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // Result side: ready in random stretches with random stall bursts, plus
  // one long hold-off on request from the stimulus so the converter fills up
  // and drops in_ready while requests keep coming.
  initial begin : result_sink
    @(posedge clk iff rst_n);
    forever begin
      if (long_hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end else if (!calm_tail && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // Check every accepted character against the oldest expectation and count
  // cycles in which neither channel moves anything.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_chars_q.size() == 0) begin
        $display("%0t: character with no request outstanding: expected none, actual %0d last %0b",
                 $time, out_char, out_last);
        mismatch_count++;
      end else begin
        if (out_char !== expected_chars_q[0].ch) begin
          $display("%0t: out_char mismatch: expected %0d, actual %0d",
                   $time, expected_chars_q[0].ch, out_char);
          mismatch_count++;
        end
        if (out_last !== expected_chars_q[0].last) begin
          $display("%0t: out_last mismatch: expected %0b, actual %0b",
                   $time, expected_chars_q[0].last, out_last);
          mismatch_count++;
        end
        void'(expected_chars_q.pop_front());
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  // Stop a hung run: nothing accepted on either channel for too long.
  initial begin : watchdog
    do @(posedge clk); while (quiet_cycles < WATCHDOG_LIMIT);
    $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("tb_binary_to_decimal_ascii_unit failed");
    $finish;
  end

  initial begin : stimulus
    logic [b2d_pkg::IN_WIDTH-1:0] value;
    logic                         negative;
    logic [63:0]                  magnitude;
    int                           kind;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, sign handling and zero.
    for (int r = 0; r < DIRECTED_COUNT; r++) begin
      maybe_idle_sender();
      send_request(directed_rows[r].value, directed_rows[r].negative, directed_rows[r].text);
    end

    // Pause the sender until every character has drained.
    in_valid <= 1'b0;
    while (expected_chars_q.size() != 0) @(posedge clk);

    // Arm the long output hold-off; requests keep flowing meanwhile.
    long_hold_req = 1'b1;

    for (int r = 0; r < RANDOM_REQUESTS; r++) begin
      if (r == RANDOM_REQUESTS - CALM_REQUESTS) calm_tail = 1'b1;
      kind     = $urandom_range(0, 9);
      negative = 1'($urandom_range(0, 1));
      if (kind < 4) begin
        // full-width bit patterns
        value = {$urandom, $urandom};
      end else if (kind < 8) begin
        // short numbers, signed when negated
        magnitude = 64'($urandom_range(0, 99999));
        value     = negative ? 64'd0 - magnitude : magnitude;
      end else if (kind == 8) begin
        // powers of ten and the all-nines just below them
        magnitude = 64'd1;
        repeat ($urandom_range(1, 19)) magnitude = magnitude * DECIMAL_BASE;
        if ($urandom_range(0, 1) == 1) magnitude = magnitude - 64'd1;
        value = negative ? 64'd0 - magnitude : magnitude;
      end else begin
        // near the top of the range
        value = {64{1'b1}} - 64'($urandom_range(0, 15));
      end
      maybe_idle_sender();
      send_request(value, negative, PREDICTED);
    end

    // Drain, then watch for stray characters a bit longer.
    in_valid <= 1'b0;
    while (expected_chars_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_chars_q.size() == 0) begin
      $display("tb_binary_to_decimal_ascii_unit passed");
    end else begin
      $display("tb_binary_to_decimal_ascii_unit failed");
    end
    $finish;
  end

endmodule
